// ===== rtl/ps2a_pkg.sv =====
package ps2a_pkg;

  // character buffer geometry
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned FILL_W     = 9;

  // scan code values
  localparam logic [7:0] SC_BREAK    = 8'hF0;
  localparam logic [7:0] SC_EXTEND   = 8'hE0;
  localparam logic [7:0] SC_LSHIFT   = 8'h12;
  localparam logic [7:0] SC_RSHIFT   = 8'h59;
  localparam logic [7:0] SC_CAPS     = 8'h58;

  localparam int unsigned TABLE_LEN  = 59;
  localparam int unsigned TAB_IDX_W  = $clog2(TABLE_LEN);

  // request kinds
  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic       func;
    logic [7:0] scan_byte;
  } in_req_t;

  typedef struct packed {
    logic              echo_valid;
    char_t             echo_char;
    logic              dropped;
    logic              read_valid;
    char_t             read_char;
    logic              has_char;
    logic [FILL_W-1:0] fill_count;
  } out_rsp_t;

  localparam char_t PLAIN_TAB [TABLE_LEN] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00
  };

  localparam char_t UPPER_TAB [TABLE_LEN] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
    7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
    7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00
  };

endpackage

// ===== rtl/ps2a_in_if.sv =====
interface ps2a_in_if import ps2a_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

// ===== rtl/ps2a_out_if.sv =====
interface ps2a_out_if import ps2a_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rsp_t rsp;

  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

// ===== rtl/ps2a_ram.sv =====
module ps2a_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ps2_scancode_to_ascii_fifo_core.sv =====
// a request accepted is registered in stage 1, then in the out stage that drives the port
// throughput: one request per cycle, limited by nothing but output back-pressure
// the character buffer is one ram with a registered read port, so pop data
// lands in the same cycle as the pointer update
// reset: asynchronous active-low, clears pointers, count, modifier flags and valids;
// ram contents are not cleared
module ps2_scancode_to_ascii_fifo_core import ps2a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ps2a_in_if.sink     in_i,
  ps2a_out_if.source  out_o
);

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic             shift_q, shift_d;
  logic             caps_q, caps_d;
  logic             break_q, break_d;

  // pipeline: stage 1 waits on ram read data, out stage drives the port
  logic     s1_valid_q;
  out_rsp_t s1_q, s1_d;
  logic     out_valid_q;
  out_rsp_t out_q, out_d;

  logic     accept;
  logic     s1_adv;
  logic     is_scan;
  logic [7:0] code;
  char_t    dec_char;
  logic     has_dec;
  logic     not_full;
  logic     push;
  logic     pop;
  char_t    ram_rdata;

  // ---------------------------------------------------------------------------
  // handshake: stage 1 moves whenever the output register is free or drained
  // ---------------------------------------------------------------------------
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  assign is_scan = (in_i.req.func == FUNC_SCAN);
  assign code    = in_i.req.scan_byte;

  // ---------------------------------------------------------------------------
  // scan byte decode and modifier tracking
  // ---------------------------------------------------------------------------
  always_comb begin
    dec_char = '0;
    shift_d  = shift_q;
    caps_d   = caps_q;
    break_d  = break_q;
    if (accept && is_scan) begin
      priority if (break_q) begin
        // release code: only shift keys matter, everything else is dropped
        break_d = 1'b0;
        if (code == SC_LSHIFT || code == SC_RSHIFT) begin
          shift_d = 1'b0;
        end
      end else if (code == SC_BREAK) begin
        break_d = 1'b1;
      end else if (code == SC_EXTEND) begin
        // extended prefix carries no information here
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_d = 1'b1;
      end else if (code == SC_CAPS) begin
        caps_d = !caps_q;
      end else if (code < 8'(TABLE_LEN)) begin
        // shift and caps cancel each other
        dec_char = (shift_q ^ caps_q) ? UPPER_TAB[code[TAB_IDX_W-1:0]]
                                      : PLAIN_TAB[code[TAB_IDX_W-1:0]];
      end else begin
        // unmapped code
      end
    end
  end

  assign has_dec  = (dec_char != '0);
  assign not_full = (held_q < CNT_W'(FIFO_DEPTH));
  assign push     = has_dec && not_full;
  assign pop      = accept && !is_scan && (held_q != '0);

  // ---------------------------------------------------------------------------
  // buffer pointers and count
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    held_d   = held_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      held_d   = held_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      held_d   = held_q - 1'b1;
    end
  end

  // push and pop never share a cycle, and a pop never targets an entry
  // written in the same cycle, so the ram needs no bypass
  ps2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (dec_char),
    .re_i    (pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // result assembly
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_d            = '0;
    s1_d.echo_valid = has_dec;
    s1_d.echo_char  = dec_char;
    s1_d.dropped    = has_dec && !not_full;
    s1_d.read_valid = pop;
    s1_d.has_char   = (held_d != '0);
    s1_d.fill_count = FILL_W'(held_d);
  end

  // read data joins the result as it leaves stage 1
  always_comb begin
    out_d           = s1_q;
    out_d.read_char = s1_q.read_valid ? ram_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      held_q      <= '0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      break_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      held_q   <= held_d;
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      break_q  <= break_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.rsp   = out_q;

`ifndef SYNTHESIS
  // count never exceeds the buffer depth
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(FIFO_DEPTH))
    else $error("buffer count above depth");

  // empty or full buffer means the pointers meet
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0 || held_q == CNT_W'(FIFO_DEPTH)) |-> (rd_ptr_q == wr_ptr_q))
    else $error("pointers disagree with count");

  // every accepted request lands in stage 1 on the next edge
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request lost before stage 1");

  // a pop always frees one slot
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (held_q == $past(held_q) - 1'b1))
    else $error("pop did not decrement count");
`endif

endmodule
